/* rtl/hcbd_pkg.sv */
// shared types and constants for the chunked body decoder
// no dependencies; used by hcbd_parser, hcbd_queue and the top level
package hcbd_pkg;

  localparam int SIZE_WIDTH_DEFAULT  = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam int         HEX_BITS  = 4;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_DIGITS  = 4'd1,
    PH_TRAIL   = 4'd2,
    PH_IGNORE  = 4'd3,
    PH_DATA    = 4'd4,
    PH_WANT_CR = 4'd5,
    PH_WANT_LF = 4'd6,
    PH_DONE    = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // bit 4 set when c is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* rtl/http_chunked_body_decoder_top.sv */
// top level of the chunked transfer body decoder
// depends on hcbd_pkg, hcbd_parser, hcbd_queue
//
// input channel: raw body bytes, one beat per byte, taken when push is high
//   and full is low; message_start marks the first byte of a new body and
//   restarts the parser before that byte is looked at
// result channel: queue style; while empty is low the oldest result sits on
//   result_kind / body_byte and leaves when pop is high
//   result_kind: body byte, end of body, or framing error
// throughput: one byte per cycle while full is low
// a result is written into the queue and is visible in the cycle after the byte that caused it
// many bytes (size lines, crlf, bytes after end or error) give no result
// the parser writes into a short result queue; when pop stays low the queue
//   fills and full rises, stalling input with no beat lost
// reset (rst, synchronous) empties the queue and puts the parser at the
//   start of a size line
module http_chunked_body_decoder_top import hcbd_pkg::*; #(
  parameter int SIZE_WIDTH  = SIZE_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       message_start,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] result_kind,
  output logic [7:0] body_byte
);

  logic    accept;
  logic    emit;
  result_t parsed;
  result_t head;

  // a byte is taken only when the queue has room for its possible result
  assign accept = push && !full;

  hcbd_parser #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .message_start(message_start),
    .emit         (emit),
    .result       (parsed)
  );

  hcbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (emit),
    .wr_data(parsed),
    .rd_en  (pop),
    .rd_data(head),
    .full   (full),
    .empty  (empty)
  );

  assign result_kind = head.kind;
  assign body_byte   = head.body;

`ifndef NO_ASSERTIONS
  // non-byte results carry a zero payload
  a_zero_body: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind != KIND_BYTE) |-> body_byte == 8'd0)
    else $error("non-byte result with nonzero payload");
`endif

endmodule

/* rtl/hcbd_parser.sv */
// front part: parses each accepted byte and, where the byte gives one, forms its result
// depends on hcbd_pkg
module hcbd_parser import hcbd_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       message_start,
  output logic       emit,
  output result_t    result
);

  phase_t                  phase, phase_next;
  logic                    pending_cr, pending_cr_next;
  logic                    line_bad, line_bad_next;
  logic [SIZE_WIDTH-1:0]   line_size, line_size_next;
  logic [SIZE_WIDTH-1:0]   bytes_left, bytes_left_next;

  // state as seen by this byte, after an optional message restart
  phase_t                  cur_phase;
  logic                    cur_pcr, cur_bad;
  logic [SIZE_WIDTH-1:0]   cur_size, cur_left, left_dec;

  phase_t                  ph1;
  logic [4:0]              hx;
  logic                    is_cr, is_lf;

  assign cur_phase = message_start ? PH_LEAD : phase;
  assign cur_pcr   = message_start ? 1'b0 : pending_cr;
  assign cur_bad   = message_start ? 1'b0 : line_bad;
  assign cur_size  = message_start ? '0 : line_size;
  assign cur_left  = message_start ? '0 : bytes_left;
  assign left_dec  = (cur_left != '0) ? cur_left - 1'b1 : cur_left;
  assign is_cr     = (data_byte == CHAR_CR);
  assign is_lf     = (data_byte == CHAR_LF);
  assign hx        = hex_decode(data_byte);

  // a held cr not followed by lf acts as whitespace
  assign ph1 = (cur_pcr && !is_lf && cur_phase == PH_DIGITS && !cur_bad) ? PH_TRAIL
                                                                          : cur_phase;

  // next state
  always_comb begin
    phase_next      = cur_phase;
    pending_cr_next = cur_pcr;
    line_bad_next   = cur_bad;
    line_size_next  = cur_size;
    bytes_left_next = cur_left;
    unique case (cur_phase) inside
      PH_DONE: begin
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = PH_WANT_CR;
      end
      PH_WANT_CR: begin
        phase_next = is_cr ? PH_WANT_LF : PH_DONE;
      end
      PH_WANT_LF: begin
        if (is_lf) begin
          phase_next      = PH_LEAD;
          pending_cr_next = 1'b0;
          line_bad_next   = 1'b0;
          line_size_next  = '0;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_LEAD, PH_DIGITS, PH_TRAIL, PH_IGNORE: begin
        if (cur_pcr && is_lf) begin
          pending_cr_next = 1'b0;
          if (cur_bad || cur_phase == PH_LEAD || cur_size == '0) begin
            phase_next = PH_DONE;
          end else begin
            bytes_left_next = cur_size;
            phase_next      = PH_DATA;
          end
        end else begin
          phase_next      = ph1;
          pending_cr_next = 1'b0;
          if (is_cr) begin
            pending_cr_next = 1'b1;
          end else if (ph1 != PH_IGNORE && !cur_bad) begin
            if (data_byte == CHAR_SEMI) begin
              if (ph1 == PH_LEAD) line_bad_next = 1'b1;
              phase_next = PH_IGNORE;
            end else if (is_ws(data_byte)) begin
              if (ph1 == PH_DIGITS) phase_next = PH_TRAIL;
            end else if (!hx[4] || ph1 == PH_TRAIL) begin
              line_bad_next = 1'b1;
            end else if (cur_size[SIZE_WIDTH-1 -: HEX_BITS] != '0) begin
              line_bad_next = 1'b1;
            end else begin
              line_size_next = {cur_size[SIZE_WIDTH-HEX_BITS-1:0], hx[3:0]};
              phase_next     = PH_DIGITS;
            end
          end
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // result for this byte
  always_comb begin
    emit        = 1'b0;
    result.kind = KIND_BYTE;
    result.body = 8'd0;
    unique case (cur_phase) inside
      PH_DONE: begin
      end
      PH_DATA: begin
        emit        = accept;
        result.body = data_byte;
      end
      PH_WANT_CR: begin
        emit        = accept && !is_cr;
        result.kind = KIND_ERROR;
      end
      PH_WANT_LF: begin
        emit        = accept && !is_lf;
        result.kind = KIND_ERROR;
      end
      PH_LEAD, PH_DIGITS, PH_TRAIL, PH_IGNORE: begin
        // a good nonzero size line opens a chunk and gives no result
        emit = accept && cur_pcr && is_lf &&
               (cur_bad || cur_phase == PH_LEAD || cur_size == '0);
        if (cur_bad || cur_phase == PH_LEAD) begin
          result.kind = KIND_ERROR;
        end else begin
          result.kind = KIND_END;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      pending_cr <= 1'b0;
      line_bad   <= 1'b0;
      line_size  <= '0;
      bytes_left <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pending_cr <= pending_cr_next;
      line_bad   <= line_bad_next;
      line_size  <= line_size_next;
      bytes_left <= bytes_left_next;
    end
  end

`ifndef NO_ASSERTIONS
  // once finished, only a message restart leaves the done phase
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !(accept && message_start)) |=> phase == PH_DONE)
    else $error("parser left done phase without message start");

  // chunk data phase always has bytes to pass
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with zero bytes left");
`endif

endmodule

/* rtl/hcbd_queue.sv */
// result queue between the parser and the pop side
// depends on hcbd_pkg
module hcbd_queue import hcbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  result_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("result written while queue full");
`endif

endmodule
